### design/plst_pkg.sv
// Shared types, codes and constants of the positional list store.
package plst_pkg;

	localparam int unsigned REQ_W = 3;
	localparam int unsigned POS_W = 11;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned DEPTH_DEFAULT = 1024;
	localparam logic [POS_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_GET    = 3'd2,
		REQ_DELRUN = 3'd3,
		REQ_SORT   = 3'd4
	} plst_req_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOVE,
		ST_GET,
		ST_SRT_KEY,
		ST_SRT_CMP,
		ST_SRT_PUT,
		ST_DONE
	} plst_state_t;

	typedef struct packed {
		logic [REQ_W-1:0]        req_type;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        run_count;
	} plst_req_t;

	typedef struct packed {
		logic                    status;
		logic signed [VAL_W-1:0] read_value;
		logic [POS_W-1:0]        length;
	} plst_res_t;

endpackage

### design/plst_if.sv
// Request and result channel interfaces of the positional list store.
interface plst_req_if;
	import plst_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        run_count;
	modport source (output valid, req_type, position, value, run_count, input ready);
	modport sink (input valid, req_type, position, value, run_count, output ready);
endinterface

interface plst_res_if;
	import plst_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    status;
	logic signed [VAL_W-1:0] read_value;
	logic [POS_W-1:0]        length;
	modport source (output valid, status, read_value, length, input ready);
	modport sink (input valid, status, read_value, length, output ready);
endinterface

### design/plst_mem.sv
// Entry memory: one write port, one read port with registered read data.
module plst_mem #(
	parameter int unsigned DEPTH = plst_pkg::DEPTH_DEFAULT,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic signed [plst_pkg::VAL_W-1:0] wr_data,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  rd_addr,
	output logic signed [plst_pkg::VAL_W-1:0] rd_data
);
	import plst_pkg::*;

	logic signed [VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/plst_ctrl.sv
// Request sequencer: checks, shift sweeps, get and insertion sort over the entry memory.
module plst_ctrl #(
	parameter int unsigned DEPTH = plst_pkg::DEPTH_DEFAULT,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  plst_pkg::plst_req_t               in_word,
	input  logic [plst_pkg::POS_W-1:0]        cap,
	output logic                              res_valid,
	input  logic                              res_take,
	output plst_pkg::plst_res_t               res_word,
	output logic                              mem_rd_en,
	output logic [AW-1:0]                     mem_rd_addr,
	input  logic signed [plst_pkg::VAL_W-1:0] mem_rd_data,
	output logic                              mem_wr_en,
	output logic [AW-1:0]                     mem_wr_addr,
	output logic signed [plst_pkg::VAL_W-1:0] mem_wr_data
);
	import plst_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned W = ((CW > POS_W) ? CW : POS_W) + 2;
	localparam logic [W-1:0] DEPTH_W = W'(DEPTH);

	plst_state_t             state_q, state_d;
	logic [CW-1:0]           count_q, count_d;
	logic [AW-1:0]           rd_addr_q, rd_addr_d;
	logic [AW-1:0]           wr_addr_q, wr_addr_d;
	logic [CW-1:0]           left_q, left_d;
	logic                    pend_q, pend_d;
	logic                    down_q, down_d;
	logic                    put_q, put_d;
	logic signed [VAL_W-1:0] key_q, key_d;
	logic [AW-1:0]           i_q, i_d;
	logic [AW-1:0]           j_q, j_d;
	logic                    status_q, status_d;
	logic signed [VAL_W-1:0] rdata_q, rdata_d;

	logic [W-1:0] pos_w, run_w, cnt_w, cap_w, lim_w, first_w;
	logic [W-1:0] r_w, ins_moves_w, del_moves_w, del_src_w, cnt_less_w, cnt_more_w;
	logic [W-1:0] nxt_w;
	logic         pos_ok, ins_ok, run_ok, del_ok, more;
	logic [AW-1:0] jm1;

	always_comb begin
		pos_w       = W'(in_word.position);
		run_w       = W'(in_word.run_count);
		cnt_w       = W'(count_q);
		cap_w       = W'(cap);
		lim_w       = (cap_w < DEPTH_W) ? cap_w : DEPTH_W;
		first_w     = pos_w - W'(1);
		pos_ok      = (pos_w != '0) && (pos_w <= cnt_w);
		ins_ok      = (pos_w != '0) && (pos_w <= cnt_w + W'(1)) && (cnt_w + W'(1) <= lim_w);
		run_ok      = pos_ok && (first_w + run_w <= cnt_w);
		r_w         = (in_word.req_type == REQ_DELRUN) ? run_w : W'(1);
		del_ok      = (in_word.req_type == REQ_DELRUN) ? run_ok : pos_ok;
		ins_moves_w = cnt_w - first_w;
		del_moves_w = (r_w == '0) ? '0 : cnt_w - first_w - r_w;
		del_src_w   = first_w + r_w;
		cnt_less_w  = cnt_w - r_w;
		cnt_more_w  = cnt_w + W'(1);
		nxt_w       = W'(i_q) + W'(1);
		more        = nxt_w < cnt_w;
		jm1         = j_q - AW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr_d;
		wr_addr_q <= wr_addr_d;
		left_q    <= left_d;
		pend_q    <= pend_d;
		down_q    <= down_d;
		put_q     <= put_d;
		key_q     <= key_d;
		i_q       <= i_d;
		j_q       <= j_d;
		status_q  <= status_d;
		rdata_q   <= rdata_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rd_addr_d   = rd_addr_q;
		wr_addr_d   = wr_addr_q;
		left_d      = left_q;
		pend_d      = pend_q;
		down_d      = down_q;
		put_d       = put_q;
		key_d       = key_q;
		i_d         = i_q;
		j_d         = j_q;
		status_d    = status_q;
		rdata_d     = rdata_q;
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = rd_addr_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = wr_addr_q;
		mem_wr_data = mem_rd_data;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					status_d = 1'b1;
					rdata_d  = '0;
					state_d  = ST_DONE;
					unique case (in_word.req_type) inside
						REQ_INSERT: begin
							if (ins_ok) begin
								status_d  = 1'b0;
								count_d   = cnt_more_w[CW-1:0];
								put_d     = 1'b1;
								key_d     = in_word.value;
								j_d       = first_w[AW-1:0];
								left_d    = ins_moves_w[CW-1:0];
								rd_addr_d = count_q[AW-1:0] - AW'(1);
								wr_addr_d = count_q[AW-1:0];
								down_d    = 1'b1;
								pend_d    = 1'b0;
								state_d   = ST_MOVE;
							end
						end
						REQ_DELETE, REQ_DELRUN: begin
							if (del_ok) begin
								status_d  = 1'b0;
								count_d   = cnt_less_w[CW-1:0];
								put_d     = 1'b0;
								left_d    = del_moves_w[CW-1:0];
								rd_addr_d = del_src_w[AW-1:0];
								wr_addr_d = first_w[AW-1:0];
								down_d    = 1'b0;
								pend_d    = 1'b0;
								state_d   = ST_MOVE;
							end
						end
						REQ_GET: begin
							if (pos_ok) begin
								status_d    = 1'b0;
								mem_rd_en   = 1'b1;
								mem_rd_addr = first_w[AW-1:0];
								state_d     = ST_GET;
							end
						end
						REQ_SORT: begin
							status_d = 1'b0;
							if (cnt_w >= W'(2)) begin
								mem_rd_en   = 1'b1;
								mem_rd_addr = AW'(1);
								i_d         = AW'(1);
								j_d         = AW'(1);
								state_d     = ST_SRT_KEY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_MOVE: begin
				if (left_q != '0) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = rd_addr_q;
					rd_addr_d   = down_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
					left_d      = left_q - CW'(1);
				end
				if (pend_q) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = wr_addr_q;
					mem_wr_data = mem_rd_data;
					wr_addr_d   = down_q ? wr_addr_q - AW'(1) : wr_addr_q + AW'(1);
				end
				pend_d = (left_q != '0);
				if ((left_q == '0) && !pend_q) begin
					if (put_q) begin
						mem_wr_en   = 1'b1;
						mem_wr_addr = j_q;
						mem_wr_data = key_q;
					end
					state_d = ST_DONE;
				end
			end
			ST_GET: begin
				rdata_d = mem_rd_data;
				state_d = ST_DONE;
			end
			ST_SRT_KEY: begin
				key_d       = mem_rd_data;
				mem_rd_en   = 1'b1;
				mem_rd_addr = jm1;
				state_d     = ST_SRT_CMP;
			end
			ST_SRT_CMP: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = j_q;
				if (mem_rd_data > key_q) begin
					mem_wr_data = mem_rd_data;
					j_d         = jm1;
					if (jm1 != '0) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = jm1 - AW'(1);
					end else begin
						state_d = ST_SRT_PUT;
					end
				end else begin
					mem_wr_data = key_q;
					if (more) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = nxt_w[AW-1:0];
						i_d         = nxt_w[AW-1:0];
						j_d         = nxt_w[AW-1:0];
						state_d     = ST_SRT_KEY;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SRT_PUT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = j_q;
				mem_wr_data = key_q;
				if (more) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = nxt_w[AW-1:0];
					i_d         = nxt_w[AW-1:0];
					j_d         = nxt_w[AW-1:0];
					state_d     = ST_SRT_KEY;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_word.status     = status_q;
	assign res_word.read_value = rdata_q;
	assign res_word.length     = cnt_w[POS_W-1:0];

endmodule

### design/positional_list_store_core.sv
// Positional list store: top level with limit register, result register and memory.
// Keeps a packed list of signed 32-bit entries in a one-read, one-write memory and serves
// one request at a time; the next request is taken as soon as the previous result sits in
// the output register. Insert at position p moves the entries from p onwards up by one, and
// delete of a run of r at p moves the entries behind the run down by r; an empty run moves
// nothing. Sort is an insertion sort run through the memory port, slowest for a list in
// descending order. No clearing pass follows reset; entries are read only after they
// were written.
module positional_list_store_core #(
	parameter int unsigned DEPTH = plst_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	plst_req_if.sink                   req,
	plst_res_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [plst_pkg::POS_W-1:0] cfg_wdata
);
	import plst_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic [POS_W-1:0]        cap_q;
	plst_req_t               req_word;
	plst_res_t               res_word;
	plst_res_t               out_word_q;
	logic                    out_valid_q;
	logic                    res_valid, res_take;
	logic                    mem_rd_en, mem_wr_en;
	logic [AW-1:0]           mem_rd_addr, mem_wr_addr;
	logic signed [VAL_W-1:0] mem_rd_data, mem_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign req_word.req_type  = req.req_type;
	assign req_word.position  = req.position;
	assign req_word.value     = req.value;
	assign req_word.run_count = req.run_count;

	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_word_q <= res_word;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_word_q.status;
	assign rsp.read_value = out_word_q.read_value;
	assign rsp.length     = out_word_q.length;

	plst_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_word     (req_word),
		.cap         (cap_q),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res_word    (res_word),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	plst_mem #(.DEPTH(DEPTH)) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

### design/plst_checker.sv
// Port checker of the positional list store and its bind to the top level.
module plst_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic                              rsp_status,
	input logic signed [plst_pkg::VAL_W-1:0] rsp_read_value,
	input logic [plst_pkg::POS_W-1:0]        rsp_length
);
	import plst_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_read_value) && $stable(rsp_length))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_read_value == '0)
		else $error("error result carries a nonzero read value");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	a_no_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready && !rsp_valid |=> !rsp_valid)
		else $error("result word without a request");

endmodule

bind positional_list_store_core plst_checker u_plst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_read_value (rsp.read_value),
	.rsp_length     (rsp.length)
);

### verif/positional_list_store_core_tb.sv
// Self-checking testbench for the positional list store core with a built-in list predictor.
module positional_list_store_core_tb;
	import plst_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEFAULT;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [POS_W-1:0] cfg_wdata;

	plst_req_if req_ch ();
	plst_res_if rsp_ch ();

	positional_list_store_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// list predictor state
	logic signed [VAL_W-1:0] list_words [DEPTH];
	int unsigned list_len = 0;
	int unsigned list_cap = CAP_RESET;

	// stimulus planning state
	int unsigned plan_len = 0;
	int unsigned plan_cap = CAP_RESET;

	plst_req_t requests_queued [$];
	plst_res_t replies_due [$];
	plst_req_t offered;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned results_seen = 0;
	int unsigned hold_left = 0;
	int unsigned sink_cycle = 0;
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;

	function automatic plst_res_t apply_list_request(plst_req_t rq);
		plst_res_t res;
		int unsigned pos;
		int unsigned run;
		int unsigned lim;
		int unsigned j;
		int k;
		logic signed [VAL_W-1:0] key;
		pos = rq.position;
		run = rq.run_count;
		lim = (list_cap < DEPTH) ? list_cap : DEPTH;
		res.status = 1'b1;
		res.read_value = '0;
		case (rq.req_type) inside
			REQ_INSERT: begin
				if (pos >= 1 && pos <= list_len + 1 && list_len + 1 <= lim) begin
					for (j = list_len; j > pos - 1; j--)
						list_words[j] = list_words[j-1];
					list_words[pos-1] = rq.value;
					list_len++;
					res.status = 1'b0;
				end
			end
			REQ_DELETE, REQ_DELRUN: begin
				if (rq.req_type == REQ_DELETE)
					run = 1;
				if (pos >= 1 && pos <= list_len && pos - 1 + run <= list_len) begin
					for (j = pos - 1; j + run < list_len; j++)
						list_words[j] = list_words[j+run];
					list_len -= run;
					res.status = 1'b0;
				end
			end
			REQ_GET: begin
				if (pos >= 1 && pos <= list_len) begin
					res.read_value = list_words[pos-1];
					res.status = 1'b0;
				end
			end
			REQ_SORT: begin
				for (j = 1; j < list_len; j++) begin
					key = list_words[j];
					k = j;
					while (k > 0 && list_words[k-1] > key) begin
						list_words[k] = list_words[k-1];
						k--;
					end
					list_words[k] = key;
				end
				res.status = 1'b0;
			end
			default: ;
		endcase
		res.length = POS_W'(list_len);
		return res;
	endfunction

	function automatic int unsigned length_after(int unsigned len, int unsigned cap,
			plst_req_t rq);
		int unsigned pos;
		int unsigned run;
		int unsigned lim;
		pos = rq.position;
		run = rq.run_count;
		lim = (cap < DEPTH) ? cap : DEPTH;
		case (rq.req_type)
			REQ_INSERT: if (pos >= 1 && pos <= len + 1 && len + 1 <= lim) return len + 1;
			REQ_DELETE: if (pos >= 1 && pos <= len) return len - 1;
			REQ_DELRUN: if (pos >= 1 && pos <= len && pos - 1 + run <= len) return len - run;
			default: ;
		endcase
		return len;
	endfunction

	function automatic plst_req_t req_word(logic [REQ_W-1:0] kind, int unsigned pos,
			logic signed [VAL_W-1:0] val, int unsigned run);
		plst_req_t rq;
		rq.req_type = kind;
		rq.position = POS_W'(pos);
		rq.value = val;
		rq.run_count = POS_W'(run);
		return rq;
	endfunction

	function automatic void push_request(plst_req_t rq);
		requests_queued.push_back(rq);
		plan_len = length_after(plan_len, plan_cap, rq);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			1: return VAL_W'(int'($urandom_range(0, 15)) - 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned pick_position(int unsigned top);
		int unsigned pos;
		pos = (top == 0) ? 1 : $urandom_range(1, top);
		if ($urandom_range(0, 11) == 0)
			pos = top + 1;
		return pos;
	endfunction

	function automatic plst_req_t make_random_request(int unsigned soft_max);
		plst_req_t rq;
		int unsigned roll;
		int unsigned grow_w;
		int unsigned pos;
		rq = req_word(REQ_GET, 0, pick_value(), 0);
		roll = $urandom_range(0, 99);
		grow_w = (plan_len < soft_max) ? 40 : 8;
		if (roll < 10) begin
			rq.req_type = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
			rq.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
			rq.run_count = POS_W'($urandom_range(0, (1 << POS_W) - 1));
		end else if (roll < 13) begin
			rq.req_type = REQ_SORT;
		end else if (roll < 13 + grow_w) begin
			rq.req_type = REQ_INSERT;
			rq.position = POS_W'(pick_position(plan_len + 1));
		end else if (roll < 38 + grow_w) begin
			rq.position = POS_W'(pick_position(plan_len));
		end else if (roll < 48 + grow_w) begin
			rq.req_type = REQ_DELRUN;
			pos = (plan_len == 0) ? 1 : $urandom_range(1, plan_len);
			rq.position = POS_W'(pos);
			rq.run_count = POS_W'($urandom_range(0, plan_len - pos + 1) +
				($urandom_range(0, 7) == 0));
		end else begin
			rq.req_type = REQ_DELETE;
			rq.position = POS_W'(pick_position(plan_len));
		end
		return rq;
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (requests_queued.size() != 0 || req_ch.valid || replies_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned cap, int unsigned count, int unsigned soft_max);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= POS_W'(cap);
		list_cap = cap;
		plan_cap = cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (count) push_request(make_random_request(soft_max));
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				replies_due.push_back(apply_list_request(offered));
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left != 0 || requests_queued.size() == 0) begin
					req_ch.valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					offered = requests_queued.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= offered.req_type;
					req_ch.position <= offered.position;
					req_ch.value <= offered.value;
					req_ch.run_count <= offered.run_count;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		plst_res_t want;
		logic take_next;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (replies_due.size() == 0) begin
					$error("result word with no request outstanding");
					err_count++;
				end else begin
					want = replies_due.pop_front();
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						err_count++;
					end
					if (rsp_ch.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value,
							rsp_ch.read_value);
						err_count++;
					end
					if (rsp_ch.length !== want.length) begin
						$error("length: expected %0d, got %0d", want.length, rsp_ch.length);
						err_count++;
					end
				end
				if (results_seen == 60 || results_seen == 330)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				take_next = 1'b0;
			end else begin
				case ((sink_cycle / 97) % 4)
					0: take_next = 1'b1;
					1: take_next = 1'($urandom_range(0, 1));
					2: take_next = ($urandom_range(0, 4) == 0);
					default: take_next = (sink_cycle % 3 != 0);
				endcase
			end
			sink_cycle++;
			rsp_ch.ready <= take_next;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** positional_list_store_core: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.position = '0;
		req_ch.value = '0;
		req_ch.run_count = '0;
		rsp_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// empty list
		push_request(req_word(REQ_SORT, 0, 0, 0));
		push_request(req_word(REQ_GET, 1, 0, 0));
		push_request(req_word(REQ_DELETE, 1, 0, 0));
		push_request(req_word(REQ_DELRUN, 1, 0, 0));
		// insert bounds and value extremes, gets, undefined request codes and a sort
		push_request(req_word(REQ_INSERT, 0, 5, 0));
		push_request(req_word(REQ_INSERT, 2, 5, 0));
		push_request(req_word(REQ_INSERT, 1, VAL_MAX, 0));
		push_request(req_word(REQ_INSERT, 1, VAL_MIN, 0));
		push_request(req_word(REQ_INSERT, 3, '1, 0));
		push_request(req_word(REQ_INSERT, 2, 0, 0));
		push_request(req_word(REQ_INSERT, (1 << POS_W) - 1, 7, 0));
		push_request(req_word(REQ_INSERT, DEPTH + 1, 7, 0));
		push_request(req_word(REQ_GET, 4, 0, 0));
		push_request(req_word(REQ_GET, 5, 0, 0));
		push_request(req_word(REQ_GET, 0, 0, 0));
		for (int t = int'(REQ_SORT) + 1; t < (1 << REQ_W); t++)
			push_request(req_word(REQ_W'(t), 1, VAL_MIN, 1));
		push_request(req_word(REQ_SORT, 0, 0, 0));
		push_request(req_word(REQ_GET, 1, 0, 0));
		push_request(req_word(REQ_GET, 4, 0, 0));
		// run delete and single delete bounds
		push_request(req_word(REQ_DELRUN, 2, 0, 0));
		push_request(req_word(REQ_DELRUN, 2, 0, (1 << POS_W) - 1));
		push_request(req_word(REQ_DELRUN, 3, 0, 3));
		push_request(req_word(REQ_DELRUN, 2, 0, 2));
		push_request(req_word(REQ_DELETE, 0, 0, 0));
		push_request(req_word(REQ_DELETE, DEPTH + 1, 0, 0));
		push_request(req_word(REQ_DELETE, 2, 0, 0));

		run_phase(CAP_RESET, 120, 24);
		run_phase(0, 20, 24);
		run_phase(5, 80, 24);
		run_phase(1, 30, 24);
		run_phase(CAP_RESET, 120, 160);
		run_phase($urandom_range(2, 40), 100, 40);
		run_phase(CAP_RESET, 100, 30);

		wait_idle();
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("** positional_list_store_core: PASSED **");
		else
			$display("** positional_list_store_core: FAILED **");
		$finish;
	end

endmodule

### filelist.f
design/plst_pkg.sv
design/plst_if.sv
design/plst_mem.sv
design/plst_ctrl.sv
design/positional_list_store_core.sv
design/plst_checker.sv
verif/positional_list_store_core_tb.sv
